FILE: rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg - shared types and constants for the polygon plane splitter
// Widths of the fixed-point fields, payload structs, register and side codes.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int NORMAL_WIDTH    = 18;
   localparam int TOL_WIDTH       = 16;
   localparam int TOL_RESET       = 66;
   localparam int ACC_WIDTH       = COORD_WIDTH + NORMAL_WIDTH + 2;
   localparam int DIST_WIDTH      = ACC_WIDTH + 1;
   localparam int MAG_WIDTH       = COORD_WIDTH + 1;
   localparam int DEN_WIDTH       = DIST_WIDTH + 1;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NORMAL_X   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NORMAL_Y   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NORMAL_Z   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PLANE_OFS  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SIDE_TOL   = 3'd4;

   typedef enum logic [1:0] {
      SIDE_FRONT  = 2'd0,
      SIDE_BEHIND = 2'd1,
      SIDE_ON     = 2'd2
   } side_type;

   localparam logic [1:0] CLASS_FRONT    = 2'd0;
   localparam logic [1:0] CLASS_BEHIND   = 2'd1;
   localparam logic [1:0] CLASS_COPLANAR = 2'd2;
   localparam logic [1:0] CLASS_SPLIT    = 2'd3;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pos_x;
      logic signed [COORD_WIDTH-1:0] pos_y;
      logic signed [COORD_WIDTH-1:0] pos_z;
      logic                          final_vertex;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic signed [COORD_WIDTH-1:0] out_z;
      logic                          goes_front;
      logic                          goes_back;
      logic                          is_crossing;
      logic                          run_end;
      logic                          polygon_end;
      logic [1:0]                    polygon_class;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [MAG_WIDTH-1:0] mag;
      logic [DEN_WIDTH-1:0] num;
      logic [DEN_WIDTH-1:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [MAG_WIDTH-1:0] quot;
   } div_stat_type;

   function automatic logic crosses(input side_type a, input side_type b);
      return (a == SIDE_FRONT && b == SIDE_BEHIND) ||
             (a == SIDE_BEHIND && b == SIDE_FRONT);
   endfunction

endpackage

FILE: rtl/core/polygon_plane_split.sv
// ----------------------------------------------------------------------------
// polygon_plane_split - streaming split of a convex polygon by a plane
// Vertices in, front/back fragment vertices and edge crossings out.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req_    | in  | req_valid/req_ready  | req_data  : req_type (vertex + last flag)
//  rsp_    | out | rsp_valid/rsp_ready  | rsp_data  : rsp_type (vertex + tags)
//  csr_    | in  | csr_valid/csr_ready  | csr_index, csr_data (register write)
//
//  A vertex without a crossing passes accept, a multiply per axis, classify
//  and result. Each crossing adds work on the one shared divide unit: a
//  set-up step, then per axis a launch step and a wait on the serial divide,
//  then one more result step. The distance uses one multiplier, one axis at a time.
//  Synchronous reset clears control and polygon state, loads config defaults.
//  A stalled rsp_ holds the sequencer; req_ready is high only when idle.
// ----------------------------------------------------------------------------
module polygon_plane_split import pps_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]     csr_data
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL  = 7'b0000010,
      ST_DIST = 7'b0000100,
      ST_DSET = 7'b0001000,
      ST_DIVS = 7'b0010000,
      ST_DIVW = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   // which result of the current vertex is being built
   typedef enum logic [2:0] {
      PH_LEAD  = 3'b001,
      PH_VERT  = 3'b010,
      PH_CLOSE = 3'b100
   } phase_type;

   // configuration registers
   logic signed [NORMAL_WIDTH-1:0] normal_ff [3];
   logic signed [COORD_WIDTH-1:0]  offset_ff;
   logic [TOL_WIDTH-1:0]           tol_ff;

   // sequencer
   state_type                      state_ff, state_in;
   phase_type                      phase_ff, phase_in;
   logic [1:0]                     axis_ff, axis_in;

   // current vertex
   logic signed [COORD_WIDTH-1:0]  cur_pos_ff [3];
   logic                           cur_last_ff;
   logic signed [ACC_WIDTH-1:0]    acc_ff, acc_in;
   logic signed [DIST_WIDTH-1:0]   dist_ff;
   side_type                       side_ff;

   // polygon state
   logic signed [COORD_WIDTH-1:0]  first_pos_ff [3];
   logic signed [DIST_WIDTH-1:0]   first_dist_ff;
   side_type                       first_side_ff;
   logic signed [COORD_WIDTH-1:0]  prev_pos_ff [3];
   logic signed [DIST_WIDTH-1:0]   prev_dist_ff;
   side_type                       prev_side_ff;
   logic                           have_first_ff, seen_front_ff, seen_back_ff;

   // crossing work
   logic [DIST_WIDTH-1:0]          num_ff;
   logic [DEN_WIDTH-1:0]           den_ff;
   logic                           neg_ff;
   logic signed [COORD_WIDTH-1:0]  xres_ff [3];

   // result register
   rsp_type                        rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // datapath nets
   logic signed [NORMAL_WIDTH+COORD_WIDTH-1:0] prod;
   logic signed [ACC_WIDTH-1:0]    acc_shift;
   logic signed [DIST_WIDTH-1:0]   dist_calc, tol_s;
   side_type                       side_calc;
   logic signed [DIST_WIDTH-1:0]   ds_sel, de_sel;
   logic [DIST_WIDTH-1:0]          ds_mag, de_mag;
   logic signed [COORD_WIDTH-1:0]  s_sel, e_sel;
   logic signed [MAG_WIDTH-1:0]    delta, s_ext, xval;
   logic [MAG_WIDTH-1:0]           delta_mag;
   logic                           close_cross, out_take, run_end, seen_f, seen_b;
   logic [1:0]                     cls;
   div_cmd_type                    div_cmd;
   div_stat_type                   div_stat;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ---- configuration writes ----
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_ff[0] <= '0;
         normal_ff[1] <= '0;
         normal_ff[2] <= NORMAL_WIDTH'(1) <<< FRAC_BITS;
         offset_ff    <= '0;
         tol_ff       <= TOL_WIDTH'(TOL_RESET);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NORMAL_X:  normal_ff[0] <= csr_data[NORMAL_WIDTH-1:0];
            CSR_NORMAL_Y:  normal_ff[1] <= csr_data[NORMAL_WIDTH-1:0];
            CSR_NORMAL_Z:  normal_ff[2] <= csr_data[NORMAL_WIDTH-1:0];
            CSR_PLANE_OFS: offset_ff    <= csr_data;
            CSR_SIDE_TOL:  tol_ff       <= csr_data[TOL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // ---- distance: one multiply per cycle, then shift, offset, classify ----
   assign prod      = normal_ff[axis_ff] * cur_pos_ff[axis_ff];
   assign acc_in    = (state_ff == ST_IDLE) ? '0 : acc_ff + ACC_WIDTH'(prod);
   assign acc_shift = acc_ff >>> FRAC_BITS;
   assign dist_calc = DIST_WIDTH'(acc_shift) + DIST_WIDTH'(offset_ff);
   assign tol_s     = signed'({{(DIST_WIDTH-TOL_WIDTH){1'b0}}, tol_ff});

   always_comb begin
      if (dist_calc > tol_s)       side_calc = SIDE_FRONT;
      else if (dist_calc < -tol_s) side_calc = SIDE_BEHIND;
      else                         side_calc = SIDE_ON;
   end

   // ---- edge operands: lead edge prev->cur, closing edge cur->first ----
   always_comb begin
      if (phase_ff == PH_CLOSE) begin
         ds_sel = dist_ff;
         de_sel = first_dist_ff;
         s_sel  = cur_pos_ff[axis_ff];
         e_sel  = first_pos_ff[axis_ff];
      end else begin
         ds_sel = prev_dist_ff;
         de_sel = dist_ff;
         s_sel  = prev_pos_ff[axis_ff];
         e_sel  = cur_pos_ff[axis_ff];
      end
   end

   assign ds_mag    = ds_sel[DIST_WIDTH-1] ? DIST_WIDTH'(-ds_sel) : DIST_WIDTH'(ds_sel);
   assign de_mag    = de_sel[DIST_WIDTH-1] ? DIST_WIDTH'(-de_sel) : DIST_WIDTH'(de_sel);
   assign s_ext     = MAG_WIDTH'(s_sel);
   assign delta     = MAG_WIDTH'(e_sel) - s_ext;
   assign delta_mag = delta[MAG_WIDTH-1] ? MAG_WIDTH'(-delta) : MAG_WIDTH'(delta);

   // truncation toward the start vertex; a zero divisor leaves the start point
   assign xval = (den_ff == '0) ? s_ext :
                 neg_ff ? s_ext - signed'(div_stat.quot) : s_ext + signed'(div_stat.quot);

   assign div_cmd.start = (state_ff == ST_DIVS);
   assign div_cmd.mag   = delta_mag;
   assign div_cmd.num   = {1'b0, num_ff};
   assign div_cmd.den   = den_ff;

   pps_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   // ---- result assembly ----
   assign close_cross = cur_last_ff && have_first_ff && crosses(side_ff, first_side_ff);
   assign run_end     = (phase_ff == PH_CLOSE) || (phase_ff == PH_VERT && !close_cross);
   assign seen_f      = seen_front_ff || (side_ff == SIDE_FRONT);
   assign seen_b      = seen_back_ff  || (side_ff == SIDE_BEHIND);

   always_comb begin
      if (seen_f && seen_b) cls = CLASS_SPLIT;
      else if (seen_f)      cls = CLASS_FRONT;
      else if (seen_b)      cls = CLASS_BEHIND;
      else                  cls = CLASS_COPLANAR;
   end

   assign out_take = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (out_take) begin
         rsp_valid_in = 1'b1;
         if (phase_ff == PH_VERT) begin
            rsp_in.out_x       = cur_pos_ff[0];
            rsp_in.out_y       = cur_pos_ff[1];
            rsp_in.out_z       = cur_pos_ff[2];
            rsp_in.goes_front  = (side_ff != SIDE_BEHIND);
            rsp_in.goes_back   = (side_ff != SIDE_FRONT);
            rsp_in.is_crossing = 1'b0;
         end else begin
            rsp_in.out_x       = xres_ff[0];
            rsp_in.out_y       = xres_ff[1];
            rsp_in.out_z       = xres_ff[2];
            rsp_in.goes_front  = 1'b1;
            rsp_in.goes_back   = 1'b1;
            rsp_in.is_crossing = 1'b1;
         end
         rsp_in.run_end       = run_end;
         rsp_in.polygon_end   = run_end && cur_last_ff;
         rsp_in.polygon_class = (run_end && cur_last_ff) ? cls : CLASS_FRONT;
      end
   end

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      axis_in  = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            axis_in = 2'd0;
            if (req_valid) state_in = ST_MUL;
         end
         ST_MUL: begin
            axis_in = axis_ff + 2'd1;
            if (axis_ff == 2'd2) state_in = ST_DIST;
         end
         ST_DIST: begin
            if (have_first_ff && crosses(prev_side_ff, side_calc)) begin
               phase_in = PH_LEAD;
               state_in = ST_DSET;
            end else begin
               phase_in = PH_VERT;
               state_in = ST_OUT;
            end
         end
         ST_DSET: begin
            axis_in  = 2'd0;
            state_in = ST_DIVS;
         end
         ST_DIVS: state_in = ST_DIVW;
         ST_DIVW: begin
            if (div_stat.done) begin
               axis_in  = axis_ff + 2'd1;
               state_in = (axis_ff == 2'd2) ? ST_OUT : ST_DIVS;
            end
         end
         ST_OUT: begin
            if (out_take) begin
               case (phase_ff)
                  PH_LEAD: phase_in = PH_VERT;
                  PH_VERT: begin
                     if (close_cross) begin
                        phase_in = PH_CLOSE;
                        state_in = ST_DSET;
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_VERT;
         axis_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         have_first_ff <= 1'b0;
         seen_front_ff <= 1'b0;
         seen_back_ff  <= 1'b0;
         first_dist_ff <= '0;
         first_side_ff <= SIDE_FRONT;
         prev_dist_ff  <= '0;
         prev_side_ff  <= SIDE_FRONT;
         for (int i = 0; i < 3; i++) begin
            first_pos_ff[i] <= '0;
            prev_pos_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         // polygon bookkeeping once the vertex's last result has gone out
         if (out_take && run_end) begin
            if (!have_first_ff) begin
               first_pos_ff  <= cur_pos_ff;
               first_dist_ff <= dist_ff;
               first_side_ff <= side_ff;
            end
            if (cur_last_ff) begin
               have_first_ff <= 1'b0;
               seen_front_ff <= 1'b0;
               seen_back_ff  <= 1'b0;
            end else begin
               prev_pos_ff   <= cur_pos_ff;
               prev_dist_ff  <= dist_ff;
               prev_side_ff  <= side_ff;
               have_first_ff <= 1'b1;
               seen_front_ff <= seen_f;
               seen_back_ff  <= seen_b;
            end
         end
      end
      rsp_ff <= rsp_in;
      acc_ff <= acc_in;
      if (req_valid && req_ready) begin
         cur_pos_ff[0] <= req_data.pos_x;
         cur_pos_ff[1] <= req_data.pos_y;
         cur_pos_ff[2] <= req_data.pos_z;
         cur_last_ff   <= req_data.final_vertex;
      end
      if (state_ff == ST_DIST) begin
         dist_ff <= dist_calc;
         side_ff <= side_calc;
      end
      if (state_ff == ST_DSET) begin
         num_ff <= ds_mag;
         den_ff <= {1'b0, ds_mag} + {1'b0, de_mag};
      end
      if (state_ff == ST_DIVS) neg_ff <= delta[MAG_WIDTH-1];
      if (state_ff == ST_DIVW && div_stat.done) xres_ff[axis_ff] <= xval[COORD_WIDTH-1:0];
   end

endmodule

FILE: rtl/core/pps_muldiv.sv
// ----------------------------------------------------------------------------
// pps_muldiv - serial scaled divide
// floor(mag * num / den), one bit of mag per cycle, radix-2 with digit 0..2.
// ----------------------------------------------------------------------------
module pps_muldiv import pps_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_cmd_type  cmd,
   output div_stat_type stat
);

   localparam int CNT_W = $clog2(MAG_WIDTH);
   localparam int T_W   = DEN_WIDTH + 3;

   logic [MAG_WIDTH-1:0] mag_ff, mag_in, quot_ff, quot_in;
   logic [DEN_WIDTH-1:0] num_ff, num_in, den_ff, den_in, rem_ff, rem_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [T_W-1:0]       trial, sub1, sub2;
   logic [1:0]           digit;

   // remainder stays below den, so 2*rem + num < 3*den
   assign trial = {2'b00, rem_ff, 1'b0} + (mag_ff[MAG_WIDTH-1] ? {3'b000, num_ff} : '0);
   assign sub1  = trial - {3'b000, den_ff};
   assign sub2  = trial - {2'b00, den_ff, 1'b0};

   always_comb begin
      mag_in   = mag_ff;
      quot_in  = quot_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      digit    = 2'd0;
      if (cmd.start) begin
         mag_in   = cmd.mag;
         num_in   = cmd.num;
         den_in   = cmd.den;
         rem_in   = '0;
         quot_in  = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!sub2[T_W-1]) begin
            digit  = 2'd2;
            rem_in = sub2[DEN_WIDTH-1:0];
         end else if (!sub1[T_W-1]) begin
            digit  = 2'd1;
            rem_in = sub1[DEN_WIDTH-1:0];
         end else begin
            rem_in = trial[DEN_WIDTH-1:0];
         end
         quot_in  = {quot_ff[MAG_WIDTH-2:0], 1'b0} + {{(MAG_WIDTH-2){1'b0}}, digit};
         mag_in   = {mag_ff[MAG_WIDTH-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(MAG_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mag_ff   <= mag_in;
      quot_ff  <= quot_in;
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      count_ff <= count_in;
   end

   assign stat.done = done_ff;
   assign stat.quot = quot_ff;

endmodule
